### hw/rtl/cfpd_pkg.sv
// ----------------------------------------------------------------------------
// cfpd_pkg
// shared types and constants for the framed packet deframer
// ----------------------------------------------------------------------------
package cfpd_pkg;

  localparam int COUNT_W          = 21;
  localparam int PAYLOAD_LIMIT    = 256;
  localparam int MAX_LENGTH_BYTES = 3;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [COUNT_W:0] PAYLOAD_LIMIT_EXT = (COUNT_W + 1)'(PAYLOAD_LIMIT);
  localparam logic [COUNT_W:0] MAX_LEN_BYTES_EXT = (COUNT_W + 1)'(MAX_LENGTH_BYTES);

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OWN_ADDRESS    = 3'd0,
    REG_MAX_VERSION    = 3'd1,
    REG_START_PATTERN  = 3'd2,
    REG_START_LENGTH   = 3'd3,
    REG_CRC_POLYNOMIAL = 3'd4,
    REG_CRC_SEED       = 3'd5,
    REG_CRC_REFLECTED  = 3'd6
  } reg_index_t;

  // per-byte status codes
  typedef enum logic [2:0] {
    ST_HUNTING      = 3'd0,
    ST_IN_FRAME     = 3'd1,
    ST_FRAME_GOOD   = 3'd2,
    ST_CRC_BAD      = 3'd3,
    ST_ADDRESS_DROP = 3'd4,
    ST_VERSION_DROP = 3'd5,
    ST_LENGTH_ERROR = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [7:0]  max_version;
    logic [31:0] start_pattern;
    logic [2:0]  start_length;
    logic [15:0] crc_polynomial;
    logic [15:0] crc_seed;
    logic        crc_reflected;
  } cfg_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           payload_byte;
    logic                 payload_valid;
    logic [COUNT_W-1:0]   payload_index;
    logic                 payload_kept;
    logic [7:0]           frame_address;
    logic [7:0]           frame_version;
    logic [COUNT_W-1:0]   frame_length;
    logic                 oversize;
    logic [15:0]          crc_computed;
    logic [15:0]          crc_received;
  } result_t;

endpackage

### hw/rtl/crc_framed_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_deframer
// byte-serial start-pattern / header / payload / crc-16 deframer
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    rx_byte
// out       output     out_valid / out_ready  status, payload_*, frame_*, crc_*
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// one transaction per cycle sustained while the output is not stalled; each byte
// sees an input register, one pass of frame logic with an unrolled crc byte update,
// and a result register, from which its result is offered
// synchronous active-high reset returns to hunting with all config at defaults
// a stalled output holds the result register and the input register; in_ready
// stays high while either one has room
//
module crc_framed_packet_deframer
  import cfpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             rx_byte,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             status,
  output logic [7:0]             payload_byte,
  output logic                   payload_valid,
  output logic [COUNT_W-1:0]     payload_index,
  output logic                   payload_kept,
  output logic [7:0]             frame_address_out,
  output logic [7:0]             frame_version_out,
  output logic [COUNT_W-1:0]     frame_length_out,
  output logic                   oversize,
  output logic [15:0]            crc_computed,
  output logic [15:0]            crc_received,

  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  logic       in_full;     // input register holds a byte
  logic [7:0] in_byte;
  logic       advance;     // input register moves into the result register
  result_t    core_result;
  result_t    res;

  // configuration registers, writes to unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address    <= 8'd1;
      cfg.max_version    <= 8'd1;
      cfg.start_pattern  <= '0;
      cfg.start_length   <= 3'd2;
      cfg.crc_polynomial <= 16'h1021;
      cfg.crc_seed       <= 16'hFFFF;
      cfg.crc_reflected  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS:    cfg.own_address    <= cfg_data[7:0];
        REG_MAX_VERSION:    cfg.max_version    <= cfg_data[7:0];
        REG_START_PATTERN:  cfg.start_pattern  <= cfg_data;
        REG_START_LENGTH:   cfg.start_length   <= cfg_data[2:0];
        REG_CRC_POLYNOMIAL: cfg.crc_polynomial <= cfg_data[15:0];
        REG_CRC_SEED:       cfg.crc_seed       <= cfg_data[15:0];
        REG_CRC_REFLECTED:  cfg.crc_reflected  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline flow: result register frees when empty or taken
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  // frame state and per-byte result
  cfpd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .rx_byte(in_byte),
    .cfg    (cfg),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_result;
    end
  end

  assign status            = res.status;
  assign payload_byte      = res.payload_byte;
  assign payload_valid     = res.payload_valid;
  assign payload_index     = res.payload_index;
  assign payload_kept      = res.payload_kept;
  assign frame_address_out = res.frame_address;
  assign frame_version_out = res.frame_version;
  assign frame_length_out  = res.frame_length;
  assign oversize          = res.oversize;
  assign crc_computed      = res.crc_computed;
  assign crc_received      = res.crc_received;

  // payload bytes only ever appear inside a frame
  a_payload_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> status == ST_IN_FRAME)
    else $error("payload byte outside frame");

  // kept flag only on payload bytes
  a_kept_is_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_kept |-> payload_valid)
    else $error("payload_kept without payload_valid");

  // received crc only reported on a crc verdict
  a_crc_rx_on_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FRAME_GOOD && status != ST_CRC_BAD |-> crc_received == '0)
    else $error("crc_received outside crc verdict");

  // input back-pressure only when both registers are occupied and stalled
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("in_ready low with room in pipeline");

endmodule

### hw/rtl/cfpd_crc.sv
// ----------------------------------------------------------------------------
// cfpd_crc
// one-byte crc-16 update, msb-first or reflected lsb-first
// ----------------------------------------------------------------------------
module cfpd_crc
  import cfpd_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] poly,
  input  logic        reflected,
  output logic [15:0] crc_out
);

  logic [15:0] poly_rev;
  logic [15:0] c;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      poly_rev[i] = poly[15-i];
    end
  end

  // eight shift steps unrolled into combinational logic
  always_comb begin
    if (reflected) begin
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ poly_rev) : (c >> 1);
      end
    end else begin
      c = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    crc_out = c;
  end

endmodule

### hw/rtl/cfpd_core.sv
// ----------------------------------------------------------------------------
// cfpd_core
// frame state and per-byte next-state / result logic
// ----------------------------------------------------------------------------
module cfpd_core
  import cfpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [7:0]    rx_byte,
  input  cfg_t          cfg,
  output result_t       result
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_t;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [7:0]         frame_address, frame_address_next;
  logic [7:0]         frame_version, frame_version_next;
  logic [COUNT_W-1:0] frame_length, frame_length_next;
  logic [7:0]         crc_high_byte, crc_high_byte_next;

  logic [15:0]        crc_upd;
  logic [2:0]         slen;
  logic [COUNT_W-1:0] hunt_count;
  logic [COUNT_W-1:0] len_k;
  logic [COUNT_W-1:0] len_bits;
  logic [15:0]        prx;
  status_t            status;
  logic               pvalid;

  cfpd_crc u_crc (
    .crc_in   (running_crc),
    .data     (rx_byte),
    .poly     (cfg.crc_polynomial),
    .reflected(cfg.crc_reflected),
    .crc_out  (crc_upd)
  );

  function automatic logic [7:0] pat_byte(input logic [31:0] pat, input logic [1:0] k);
    logic [31:0] s;
    s = pat >> {k, 3'b000};
    return s[7:0];
  endfunction

  always_comb begin
    priority if (cfg.start_length == 3'd0) slen = 3'd1;
    else if (cfg.start_length > 3'd4)      slen = 3'd4;
    else                                   slen = cfg.start_length;
  end

  // pattern match counter with restart at the first byte
  always_comb begin
    priority if (byte_count < COUNT_W'(slen)
                 && rx_byte == pat_byte(cfg.start_pattern, byte_count[1:0])) begin
      hunt_count = byte_count + COUNT_W'(1);
    end else if (rx_byte == pat_byte(cfg.start_pattern, 2'd0)) begin
      hunt_count = COUNT_W'(1);
    end else begin
      hunt_count = '0;
    end
  end

  assign len_k = byte_count - COUNT_W'(2);

  // 7-bit group placed at its varint position, bits past 21 discarded
  always_comb begin
    unique case (len_k[1:0])
      2'd0:    len_bits = COUNT_W'(rx_byte[6:0]);
      2'd1:    len_bits = COUNT_W'(rx_byte[6:0]) << 7;
      2'd2:    len_bits = COUNT_W'(rx_byte[6:0]) << 14;
      default: len_bits = '0;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    frame_address_next = frame_address;
    frame_version_next = frame_version;
    frame_length_next  = frame_length;
    crc_high_byte_next = crc_high_byte;
    status             = ST_IN_FRAME;
    pvalid             = 1'b0;
    prx                = '0;

    if (phase == PH_HEADER || phase == PH_PAYLOAD) begin
      running_crc_next = crc_upd;
    end

    unique case (phase)
      PH_HUNT: begin
        if (hunt_count >= COUNT_W'(slen)) begin
          phase_next         = PH_HEADER;
          byte_count_next    = '0;
          frame_address_next = '0;
          frame_version_next = '0;
          frame_length_next  = '0;
          running_crc_next   = cfg.crc_seed;
        end else begin
          byte_count_next = hunt_count;
          status          = ST_HUNTING;
        end
      end
      PH_HEADER: begin
        priority if (byte_count == '0) begin
          frame_address_next = rx_byte;
          if (rx_byte != 8'h00 && rx_byte != cfg.own_address) begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
            status          = ST_ADDRESS_DROP;
          end else begin
            byte_count_next = COUNT_W'(1);
          end
        end else if (byte_count == COUNT_W'(1)) begin
          frame_version_next = rx_byte;
          if (rx_byte > cfg.max_version) begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
            status          = ST_VERSION_DROP;
          end else begin
            byte_count_next = COUNT_W'(2);
          end
        end else begin
          if ({1'b0, len_k} >= MAX_LEN_BYTES_EXT || len_k > COUNT_W'(3)) begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
            status          = ST_LENGTH_ERROR;
          end else begin
            frame_length_next = frame_length | len_bits;
            if (!rx_byte[7]) begin
              phase_next      = (frame_length_next != '0) ? PH_PAYLOAD : PH_CRC;
              byte_count_next = '0;
            end else begin
              byte_count_next = byte_count + COUNT_W'(1);
            end
          end
        end
      end
      PH_PAYLOAD: begin
        pvalid = 1'b1;
        if ({1'b0, byte_count} + (COUNT_W + 1)'(1) >= {1'b0, frame_length}) begin
          phase_next      = PH_CRC;
          byte_count_next = '0;
        end else begin
          byte_count_next = byte_count + COUNT_W'(1);
        end
      end
      PH_CRC: begin
        if (byte_count == '0) begin
          crc_high_byte_next = rx_byte;
          byte_count_next    = COUNT_W'(1);
        end else begin
          prx             = {crc_high_byte, rx_byte};
          status          = (prx == running_crc) ? ST_FRAME_GOOD : ST_CRC_BAD;
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_comb begin
    result.status        = status;
    result.payload_byte  = pvalid ? rx_byte : 8'h00;
    result.payload_valid = pvalid;
    result.payload_index = pvalid ? byte_count : '0;
    result.payload_kept  = pvalid && ({1'b0, byte_count} < PAYLOAD_LIMIT_EXT);
    result.frame_address = frame_address_next;
    result.frame_version = frame_version_next;
    result.frame_length  = frame_length_next;
    result.oversize      = {1'b0, frame_length_next} > PAYLOAD_LIMIT_EXT;
    result.crc_computed  = running_crc_next;
    result.crc_received  = prx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_count    <= '0;
      running_crc   <= '0;
      frame_address <= '0;
      frame_version <= '0;
      frame_length  <= '0;
      crc_high_byte <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      frame_address <= frame_address_next;
      frame_version <= frame_version_next;
      frame_length  <= frame_length_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

endmodule
